// ----- hw/rtl/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared sizes, gap table and bundle types for the Shell sort block.
// ----------------------------------------------------------------------------
package ssc_pkg;

	localparam int MAX_ELEMS = 64;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = $clog2(MAX_ELEMS);
	localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
	localparam int GAP_COUNT = 8;
	localparam int GIDX_W    = $clog2(GAP_COUNT);
	localparam int GAP_W     = 10;

	// Ciura gap sequence, smallest first
	localparam logic [GAP_W-1:0] CIURA_GAPS [GAP_COUNT] = '{
		10'd1, 10'd4, 10'd10, 10'd23, 10'd57, 10'd132, 10'd301, 10'd701
	};

	// element store access: one write port and one read address
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// sort launch from the load side
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] count;
	} sort_cmd_t;

endpackage

// ----- hw/rtl/ssc_if.sv -----
// ----------------------------------------------------------------------------
// ssc_if
// Valid/ready stream channels for element input and sorted output.
// ----------------------------------------------------------------------------
interface ssc_in_if;
	logic                     valid;
	logic                     ready;
	logic signed [ssc_pkg::DATA_W-1:0] value;
	logic                     final_item;

	modport source (output valid, output value, output final_item, input ready);
	modport sink (input valid, input value, input final_item, output ready);
endinterface

interface ssc_out_if;
	logic                     valid;
	logic                     ready;
	logic signed [ssc_pkg::DATA_W-1:0] sorted_value;
	logic                     final_result;

	modport source (output valid, output sorted_value, output final_result, input ready);
	modport sink (input valid, input sorted_value, input final_result, output ready);
endinterface

// ----- hw/rtl/ssc_ram.sv -----
// ----------------------------------------------------------------------------
// ssc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/ssc_engine.sv -----
// ----------------------------------------------------------------------------
// ssc_engine
// Shell sort sequencer: gapped insertion passes over the element store.
// ----------------------------------------------------------------------------
module ssc_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssc_pkg::sort_cmd_t           cmd,
	input  logic [ssc_pkg::DATA_W-1:0]   rdata,
	output ssc_pkg::ram_req_t            req,
	output logic                         done
);

	localparam logic [2:0] E_IDLE = 3'd0;
	localparam logic [2:0] E_PASS = 3'd1;
	localparam logic [2:0] E_NEXT = 3'd2;
	localparam logic [2:0] E_HOLD = 3'd3;
	localparam logic [2:0] E_CMP  = 3'd4;
	localparam logic [2:0] E_PUT  = 3'd5;

	logic [2:0]                   st_q;
	logic [ssc_pkg::CNT_W-1:0]    n_q;
	logic [ssc_pkg::GIDX_W-1:0]   gidx_q;
	logic [ssc_pkg::CNT_W-1:0]    outer_q;
	logic [ssc_pkg::CNT_W-1:0]    inner_q;
	logic [ssc_pkg::DATA_W-1:0]   held_q;
	logic                         done_q;

	logic [ssc_pkg::GIDX_W-1:0]   first_gidx;
	logic [ssc_pkg::CNT_W-1:0]    gap;
	logic [ssc_pkg::CNT_W-1:0]    inner_dn;
	logic                         shift;

	// largest gap below the element count, gap 1 when none
	always_comb begin
		first_gidx = '0;
		for (int g = 0; g < ssc_pkg::GAP_COUNT; g++) begin
			if (ssc_pkg::CIURA_GAPS[g] < ssc_pkg::GAP_W'(cmd.count)) begin
				first_gidx = ssc_pkg::GIDX_W'(g);
			end
		end
	end

	// gaps in use are below the count, so the truncation is lossless
	assign gap      = ssc_pkg::CIURA_GAPS[gidx_q][ssc_pkg::CNT_W-1:0];
	assign inner_dn = inner_q - gap;
	assign shift    = $signed(rdata) > $signed(held_q);
	assign done     = done_q;

	always_comb begin
		req.we    = 1'b0;
		req.waddr = inner_q[ssc_pkg::ADDR_W-1:0];
		req.wdata = held_q;
		req.raddr = outer_q[ssc_pkg::ADDR_W-1:0];
		unique case (st_q)
			E_HOLD: begin
				req.raddr = outer_q[ssc_pkg::ADDR_W-1:0] - gap[ssc_pkg::ADDR_W-1:0];
			end
			E_CMP: begin
				req.we = 1'b1;
				if (shift) begin
					req.wdata = rdata;
					req.raddr = inner_dn[ssc_pkg::ADDR_W-1:0] - gap[ssc_pkg::ADDR_W-1:0];
				end
			end
			E_PUT: begin
				req.we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= E_IDLE;
			n_q     <= '0;
			gidx_q  <= '0;
			outer_q <= '0;
			inner_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				E_IDLE: begin
					if (cmd.start) begin
						n_q    <= cmd.count;
						gidx_q <= first_gidx;
						st_q   <= E_PASS;
					end
				end
				E_PASS: begin
					outer_q <= gap;
					st_q    <= E_NEXT;
				end
				E_NEXT: begin
					if (outer_q < n_q) begin
						st_q <= E_HOLD;
					end else if (gidx_q == '0) begin
						done_q <= 1'b1;
						st_q   <= E_IDLE;
					end else begin
						gidx_q <= gidx_q - 1'b1;
						st_q   <= E_PASS;
					end
				end
				E_HOLD: begin
					inner_q <= outer_q;
					st_q    <= E_CMP;
				end
				E_CMP: begin
					if (shift) begin
						inner_q <= inner_dn;
						if (inner_dn < gap) begin
							st_q <= E_PUT;
						end
					end else begin
						outer_q <= outer_q + 1'b1;
						st_q    <= E_NEXT;
					end
				end
				E_PUT: begin
					outer_q <= outer_q + 1'b1;
					st_q    <= E_NEXT;
				end
				default: begin
					st_q <= E_IDLE;
				end
			endcase
		end
	end

	// held value is payload, no reset
	always_ff @(posedge clk) begin
		if (st_q == E_HOLD) begin
			held_q <= rdata;
		end
	end

endmodule

// ----- hw/rtl/shell_sort_ciura_gaps_top.sv -----
// ----------------------------------------------------------------------------
// shell_sort_ciura_gaps_top
// Loads a set of signed values, Shell sorts it with Ciura gaps, streams it out.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                        | transfer when
//  --------+-----+--------------------------------+------------------------
//  din     | in  | value[31:0], final_item        | din.valid & din.ready
//  dout    | out | sorted_value[31:0], final_result| dout.valid & dout.ready
//
// Loading accepts one element per cycle. The final element starts the sort,
// which runs out of the single-port-pair element RAM, one gapped insertion
// pass per gap, from the largest gap below the count down to gap 1.
// Emission reads each element from the RAM, then loads the output register.
// After reset the block loads at once; no clearing pass is needed.
// din is held off during sort and emit; a stalled dout holds its register,
// and din reopens while the last result still waits to be taken.
// ----------------------------------------------------------------------------
module shell_sort_ciura_gaps_top (
	input  logic        clk,
	input  logic        arst_n,
	ssc_in_if.sink      din,
	ssc_out_if.source   dout
);

	localparam logic [1:0] T_LOAD = 2'd0;
	localparam logic [1:0] T_SORT = 2'd1;
	localparam logic [1:0] T_ERD  = 2'd2;
	localparam logic [1:0] T_ELD  = 2'd3;

	logic [1:0]                       st_q;
	logic [ssc_pkg::CNT_W-1:0]        cnt_q;
	logic [ssc_pkg::ADDR_W-1:0]       idx_q;
	logic                             ovalid_q;
	logic [ssc_pkg::DATA_W-1:0]       odata_q;
	logic                             olast_q;

	logic                             in_xfer;
	logic                             out_xfer;
	logic                             full;
	logic [ssc_pkg::CNT_W-1:0]        cnt_nx;
	logic                             last_idx;

	ssc_pkg::sort_cmd_t               cmd;
	ssc_pkg::ram_req_t                eng_req;
	ssc_pkg::ram_req_t                req;
	logic [ssc_pkg::DATA_W-1:0]       rdata;
	logic                             sort_done;

	assign din.ready = (st_q == T_LOAD);
	assign in_xfer   = din.valid && din.ready;
	assign out_xfer  = ovalid_q && dout.ready;

	// a full store drops the value, the final mark still counts
	assign full   = (cnt_q == ssc_pkg::CNT_W'(ssc_pkg::MAX_ELEMS));
	assign cnt_nx = full ? cnt_q : cnt_q + 1'b1;

	assign last_idx = (ssc_pkg::CNT_W'(idx_q) + 1'b1) == cnt_q;

	assign cmd.start = in_xfer && din.final_item;
	assign cmd.count = cnt_nx;

	assign dout.valid        = ovalid_q;
	assign dout.sorted_value = odata_q;
	assign dout.final_result = olast_q;

	// RAM port ownership: engine while sorting, load/emit otherwise
	always_comb begin
		if (st_q == T_SORT) begin
			req = eng_req;
		end else begin
			req.we    = in_xfer && !full;
			req.waddr = cnt_q[ssc_pkg::ADDR_W-1:0];
			req.wdata = din.value;
			req.raddr = idx_q;
		end
	end

	ssc_ram #(
		.WIDTH (ssc_pkg::DATA_W),
		.DEPTH (ssc_pkg::MAX_ELEMS)
	) u_store (
		.clk   (clk),
		.we    (req.we),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.raddr (req.raddr),
		.rdata (rdata)
	);

	ssc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rdata  (rdata),
		.req    (eng_req),
		.done   (sort_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= T_LOAD;
			cnt_q    <= '0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_xfer) begin
				ovalid_q <= 1'b0;
			end
			unique case (st_q)
				T_LOAD: begin
					if (in_xfer) begin
						cnt_q <= cnt_nx;
						if (din.final_item) begin
							st_q <= T_SORT;
						end
					end
				end
				T_SORT: begin
					if (sort_done) begin
						idx_q <= '0;
						st_q  <= T_ERD;
					end
				end
				T_ERD: begin
					// read issued this cycle; proceed once the output slot frees
					if (!ovalid_q || dout.ready) begin
						st_q <= T_ELD;
					end
				end
				T_ELD: begin
					ovalid_q <= 1'b1;
					if (last_idx) begin
						cnt_q <= '0;
						st_q  <= T_LOAD;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q  <= T_ERD;
					end
				end
				default: begin
					st_q <= T_LOAD;
				end
			endcase
		end
	end

	// output payload, no reset
	always_ff @(posedge clk) begin
		if (st_q == T_ELD) begin
			odata_q <= rdata;
			olast_q <= last_idx;
		end
	end

endmodule
